// ===== src/ppt_pkg.sv =====
package ppt_pkg;

  // field widths
  localparam int CAPTURE_W = 16;
  localparam int PERIOD_W  = 17;
  localparam int CFG_W     = 17;

  // default window length
  localparam int WINDOW_SIZE_DEF = 8;

  // reset value of counter_period
  localparam logic [CFG_W-1:0] CPERIOD_RESET = CFG_W'(65536);

  // register index decode (paddr[2])
  localparam logic REG_COUNTER_PERIOD = 1'b0;

  // divider status toward the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/pulse_period_trimmed_mean_top.sv =====
// A result word is formed after the capture that fills the window, through these
// steps in order: a store read per entry, drain, trim, divide, output load.
// Throughput: one word per cycle between window ends; the input stalls for that sweep
// and while an earlier result word still waits in the output register.
// Reset (rst, synchronous): pair phase, fill count and output valid cleared,
// counter_period = 65536; store contents are never read before being rewritten.
module pulse_period_trimmed_mean_top import ppt_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // capture input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] capture_value
  input  logic        s_tuser,   // [0] wrapped
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [16:0] average_period, [23:17] zero
);

  localparam int IDX_W = $clog2(WINDOW_SIZE);
  localparam int SUM_W = PERIOD_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SIZE - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_TRIM,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t               state;
  logic [CFG_W-1:0]     counter_period;
  logic [CAPTURE_W-1:0] first_capture;
  logic                 pair_phase;
  logic [IDX_W-1:0]     fill_idx;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_pending;
  logic [IDX_W-1:0]     data_idx;
  logic [PERIOD_W-1:0]  hi;
  logic [PERIOD_W-1:0]  lo;
  logic [IDX_W-1:0]     hi_idx;
  logic [IDX_W-1:0]     lo_idx;
  logic [SUM_W-1:0]     sum;
  logic [PERIOD_W-1:0]  avg;

  logic                 in_acc;
  logic                 cfg_wr;
  logic [PERIOD_W-1:0]  period;
  logic                 st_we;
  logic                 st_re;
  logic [PERIOD_W-1:0]  rdata;
  logic                 div_start;
  logic [SUM_W-1:0]     trim_sum;
  logic                 trim_one;
  logic [PERIOD_W-1:0]  div_q;
  div_stat_t            div_stat;

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_period <= CPERIOD_RESET;
    end else if (cfg_wr && paddr[2] == REG_COUNTER_PERIOD) begin
      counter_period <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_COUNTER_PERIOD) ? {(32-CFG_W)'(0), counter_period} : '0;

  // period from the pair, modulo 2^17
  always_comb begin
    if (s_tuser) begin
      period = counter_period - {1'b0, first_capture} + {1'b0, s_tdata};
    end else begin
      period = {1'b0, s_tdata} - {1'b0, first_capture};
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign st_we    = in_acc && pair_phase;
  assign st_re    = (state == ST_SCAN);

  ppt_store #(
    .DEPTH (WINDOW_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (fill_idx),
    .wdata (period),
    .re    (st_re),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  // drop max, and min when it sits elsewhere
  assign trim_one  = (hi_idx == lo_idx);
  assign trim_sum  = sum - SUM_W'(hi) - ((hi_idx != lo_idx) ? SUM_W'(lo) : '0);
  assign div_start = (state == ST_TRIM) && !div_stat.busy;

  ppt_div #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .DVD_W       (SUM_W),
    .Q_W         (PERIOD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (trim_sum),
    .drop_one (trim_one),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // max/min/sum over the read stream
  always_ff @(posedge clk) begin
    if (rd_pending) begin
      if (data_idx == '0) begin
        hi     <= rdata;
        lo     <= rdata;
        hi_idx <= '0;
        lo_idx <= '0;
        sum    <= SUM_W'(rdata);
      end else begin
        if (rdata > hi) begin
          hi     <= rdata;
          hi_idx <= data_idx;
        end
        if (rdata < lo) begin
          lo     <= rdata;
          lo_idx <= data_idx;
        end
        sum <= sum + SUM_W'(rdata);
      end
    end
  end

  // control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pair_phase <= 1'b0;
      fill_idx   <= '0;
      rd_idx     <= '0;
      rd_pending <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      rd_pending <= st_re;
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (!pair_phase) begin
              first_capture <= s_tdata;
              pair_phase    <= 1'b1;
            end else begin
              pair_phase <= 1'b0;
              if (fill_idx == LAST_IDX) begin
                fill_idx <= '0;
                rd_idx   <= '0;
                state    <= ST_SCAN;
              end else begin
                fill_idx <= fill_idx + 1'b1;
              end
            end
          end
        end
        ST_SCAN: begin
          data_idx <= rd_idx;
          rd_idx   <= rd_idx + 1'b1;
          if (rd_idx == LAST_IDX) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_TRIM;
        end
        ST_TRIM: begin
          if (div_start) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            avg      <= div_q;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {(24-PERIOD_W)'(0), avg};

endmodule

// ===== src/ppt_store.sv =====
module ppt_store import ppt_pkg::*; #(
  parameter int DEPTH  = WINDOW_SIZE_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [PERIOD_W-1:0] wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output logic [PERIOD_W-1:0] rdata
);

  logic [PERIOD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ppt_div.sv =====
module ppt_div import ppt_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  parameter int DVD_W       = PERIOD_W + $clog2(WINDOW_SIZE),
  parameter int Q_W         = PERIOD_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic             drop_one,   // 1: divide by WINDOW_SIZE-1, else by WINDOW_SIZE-2
  output logic [Q_W-1:0]   quotient,
  output div_stat_t        stat
);

  // q = (x * ceil(2^SHIFT / d)) >> SHIFT is exact for every x below 2^DVD_W
  localparam int SHIFT = DVD_W + $clog2(WINDOW_SIZE - 1);
  localparam int RCP_W = DVD_W + 2;
  localparam int PRD_W = DVD_W + RCP_W;
  localparam longint unsigned SCALE = 64'd1 << SHIFT;
  localparam logic [RCP_W-1:0] RCP_ONE =
    RCP_W'((SCALE + 64'(WINDOW_SIZE - 2)) / 64'(WINDOW_SIZE - 1));
  localparam logic [RCP_W-1:0] RCP_TWO =
    RCP_W'((SCALE + 64'(WINDOW_SIZE - 3)) / 64'(WINDOW_SIZE - 2));

  logic [DVD_W-1:0] dvd;
  logic [RCP_W-1:0] rcp;
  logic [PRD_W-1:0] product;
  logic [Q_W-1:0]   quo;
  logic             busy;
  logic             done;

  // reciprocal multiply on the registered operands
  assign product = {RCP_W'(0), dvd} * {DVD_W'(0), rcp};

  // an accepted start latches the operands, busy then takes the product, done follows busy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start && !busy;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvd <= dividend;
      rcp <= drop_one ? RCP_ONE : RCP_TWO;
    end
    if (busy) begin
      quo <= product[SHIFT +: Q_W];
    end
  end

  // quotient never exceeds the largest period
  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== src/ppt_checker.sv =====
module ppt_checker import ppt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a result never follows an accepted capture on the next edge
  a_no_fast: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared without a window sweep");

  // pad bits above the period are zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:17] == 7'd0)
    else $error("nonzero pad bits in result word");

  // counter_period reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == REG_COUNTER_PERIOD
    |=> paddr[2] != REG_COUNTER_PERIOD || prdata == {15'd0, $past(pwdata[16:0])})
    else $error("counter_period readback mismatch");

endmodule

bind pulse_period_trimmed_mean_top ppt_checker u_ppt_checker (.*);

// ===== sim/pulse_period_trimmed_mean_top_tb.sv =====
module pulse_period_trimmed_mean_top_tb;
  import ppt_pkg::*;

  localparam int WIN          = WINDOW_SIZE_DEF;
  // idle margin after a window end; kept generous
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_WORDS  = 145;
  localparam int NUM_PHASES   = 5;

  // register map: counter_period at index 0, the other decode is unused
  localparam logic [2:0] CP_ADDR    = {REG_COUNTER_PERIOD, 2'b00};
  localparam logic [2:0] SPARE_ADDR = {~REG_COUNTER_PERIOD, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] capture_value
  logic        s_tuser = 1'b0; // [0] wrapped
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [16:0] average_period, [23:17] zero

  // directed row: capture word plus an optional hand-computed average
  typedef struct packed {
    logic [CAPTURE_W-1:0] cap;
    logic                 wrap;
    logic                 has_avg;
    logic [PERIOD_W-1:0]  avg;
  } capture_row_t;

  capture_row_t capture_rows[$];

  // period tracker state
  logic [CFG_W-1:0]     cp_model = CPERIOD_RESET;
  logic [CAPTURE_W-1:0] first_cap = '0;
  logic                 pair_open = 1'b0;
  logic [PERIOD_W-1:0]  periods[WIN];
  int                   fill = 0;

  logic [PERIOD_W-1:0] avg_expected[$];

  int err_count = 0;
  int words_sent = 0;
  int avgs_checked = 0;
  int reg_writes = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;
  bit hold_pending = 1'b0;

  pulse_period_trimmed_mean_top #(.WINDOW_SIZE(WIN)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mean of the window without the first max and first min entry
  function automatic logic [PERIOD_W-1:0] trimmed_average();
    int hi_i;
    int lo_i;
    int cnt;
    logic [31:0] sum;
    hi_i = 0;
    lo_i = 0;
    cnt = 0;
    sum = '0;
    for (int i = 1; i < WIN; i++) begin
      if (periods[i] > periods[hi_i]) hi_i = i;
      if (periods[i] < periods[lo_i]) lo_i = i;
    end
    for (int i = 0; i < WIN; i++) begin
      if (i != hi_i && i != lo_i) begin
        sum += periods[i];
        cnt++;
      end
    end
    return PERIOD_W'(sum / cnt);
  endfunction

  // advance the pair/window state by one capture; returns 1 when a mean is due
  function automatic bit track_capture(input logic [CAPTURE_W-1:0] cap, input logic wrap,
                                       output logic [PERIOD_W-1:0] avg);
    logic [PERIOD_W-1:0] period;
    avg = '0;
    if (!pair_open) begin
      first_cap = cap;
      pair_open = 1'b1;
      return 1'b0;
    end
    pair_open = 1'b0;
    // modulo 2^17 falls out of the 17-bit width
    period = wrap ? cp_model - {1'b0, first_cap} + {1'b0, cap}
                  : {1'b0, cap} - {1'b0, first_cap};
    periods[fill] = period;
    fill++;
    if (fill < WIN) return 1'b0;
    avg = trimmed_average();
    for (int i = 0; i < WIN; i++) periods[i] = '0;
    fill = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic add_row(input logic [CAPTURE_W-1:0] cap, input logic wrap,
                         input logic has_avg, input logic [PERIOD_W-1:0] avg);
    capture_rows.push_back({cap, wrap, has_avg, avg});
  endtask

  // offer one capture word, with idle cycles drawn cycle by cycle before it
  task automatic send_word(input logic [CAPTURE_W-1:0] cap, input logic wrap,
                           input logic has_avg, input logic [PERIOD_W-1:0] typed_avg);
    logic [PERIOD_W-1:0] avg;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cap;
    s_tuser  <= wrap;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    if (track_capture(cap, wrap, avg)) avg_expected.push_back(has_avg ? typed_avg : avg);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
    if (addr == CP_ADDR) cp_model = value[CFG_W-1:0];
  endtask

  task automatic check_reg();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CP_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(cp_model)) report_mismatch("counter_period readback", prdata,
                                                  32'(cp_model));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle();
    while (avg_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed capture pairs around a drifting base period, some noise
  task automatic run_phase(input int n);
    int modulus;
    int base;
    int jit;
    int p;
    int f;
    int total;
    int start;
    logic [CAPTURE_W-1:0] cap;
    modulus = (cp_model == 0 || cp_model > 65536) ? 65536 : int'(cp_model);
    base = $urandom_range(1, 3000);
    jit = 2;
    start = words_sent;
    while (words_sent - start < n) begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: base = $urandom_range(1, 50);
          1: base = $urandom_range(51, 3000);
          2: base = $urandom_range(3001, 65535);
          default: base = modulus;
        endcase
        case ($urandom_range(3))
          0: jit = 0;
          1: jit = 2;
          2: jit = 40;
          default: jit = base / 4;
        endcase
      end
      if (pair_open || $urandom_range(99) < 20) begin
        case ($urandom_range(3))
          0: cap = '0;
          1: cap = '1;
          default: cap = CAPTURE_W'($urandom_range(65535));
        endcase
        send_word(cap, 1'($urandom_range(1)), 1'b0, '0);
      end else begin
        p = base - jit + int'($urandom_range(2 * jit));
        if (p < 1) p = 1;
        f = $urandom_range(modulus - 1);
        total = f + p;
        send_word(CAPTURE_W'(f), 1'($urandom_range(1)), 1'b0, '0);
        send_word(CAPTURE_W'(total % modulus), total >= modulus, 1'b0, '0);
      end
    end
  endtask

  // result side: random back-pressure, plus one long hold on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // compare each average against the oldest one pending
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (avg_expected.size() == 0) begin
        report_mismatch("unexpected average_period", 32'(m_tdata), 32'd0);
      end else begin
        if (m_tdata[PERIOD_W-1:0] !== avg_expected[0])
          report_mismatch("average_period", 32'(m_tdata[PERIOD_W-1:0]),
                          32'(avg_expected[0]));
        if (m_tdata[23:PERIOD_W] !== '0)
          report_mismatch("tdata padding", 32'(m_tdata[23:PERIOD_W]), 32'd0);
        void'(avg_expected.pop_front());
        avgs_checked++;
      end
    end
  end

  // watchdog on cycles without any accepted word or register access
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] cp_value;
    for (int i = 0; i < WIN; i++) periods[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    check_reg();

    // all-equal window: one entry dropped, mean of 7 x 65536
    add_row(16'd0,     1'b0, 1'b0, '0);  add_row(16'd0,     1'b1, 1'b0, '0);
    add_row(16'd65535, 1'b1, 1'b0, '0);  add_row(16'd65535, 1'b1, 1'b0, '0);
    add_row(16'd1,     1'b0, 1'b0, '0);  add_row(16'd1,     1'b1, 1'b0, '0);
    add_row(16'd32768, 1'b1, 1'b0, '0);  add_row(16'd32768, 1'b1, 1'b0, '0);
    add_row(16'd43690, 1'b0, 1'b0, '0);  add_row(16'd43690, 1'b1, 1'b0, '0);
    add_row(16'd21845, 1'b1, 1'b0, '0);  add_row(16'd21845, 1'b1, 1'b0, '0);
    add_row(16'd65534, 1'b0, 1'b0, '0);  add_row(16'd65534, 1'b1, 1'b0, '0);
    add_row(16'd255,   1'b1, 1'b0, '0);  add_row(16'd255,   1'b1, 1'b1, 17'd65536);
    // earlier second capture without wrap: negative difference wraps to 65537
    add_row(16'd65535, 1'b0, 1'b0, '0);  add_row(16'd0,     1'b0, 1'b0, '0);
    // widest plain difference
    add_row(16'd0,     1'b1, 1'b0, '0);  add_row(16'd65535, 1'b0, 1'b0, '0);
    // wrapped pairs
    add_row(16'd100,   1'b0, 1'b0, '0);  add_row(16'd50,    1'b1, 1'b0, '0);
    add_row(16'd40000, 1'b1, 1'b0, '0);  add_row(16'd1,     1'b1, 1'b0, '0);

    tx_idle_pct = 18;
    rx_idle_pct = 81;
    foreach (capture_rows[i])
      send_word(capture_rows[i].cap, capture_rows[i].wrap, capture_rows[i].has_avg,
                capture_rows[i].avg);
    s_tvalid <= 1'b0;

    // random phases, each under its own counter period and one of three idle patterns
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: cp_value = CFG_W'($urandom_range(2, 65535));
        1: cp_value = 17'd1;
        2: cp_value = 17'd131071;
        3: cp_value = 17'd0;
        default: cp_value = CPERIOD_RESET;
      endcase
      if (ph == NUM_PHASES - 1) begin
        // write to the unused decode must leave counter_period alone
        write_reg(SPARE_ADDR, 32'd5);
        check_reg();
      end
      write_reg(CP_ADDR, 32'(cp_value));
      check_reg();
      if (ph < 2) begin
        tx_idle_pct = 18;
        rx_idle_pct = 81;
      end else if (ph < 4) begin
        tx_idle_pct = 81;
        rx_idle_pct = 18;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_pending = 1'b1;
      end
      run_phase(PHASE_WORDS);
      s_tvalid <= 1'b0;
    end

    while (avg_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d capture words, %0d trimmed means checked, %0d register writes",
             words_sent, avgs_checked, reg_writes);
    $display("Covered periods random/1/131071/0/65536, both idle mixes, %0d-cycle hold",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ppt_pkg.sv
src/ppt_store.sv
src/ppt_div.sv
src/pulse_period_trimmed_mean_top.sv
src/ppt_checker.sv
sim/pulse_period_trimmed_mean_top_tb.sv
